// ===== sv/best_fit_block_allocator_top_macros.svh =====
// Assertion macros for the best-fit block allocator
`ifndef BEST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/bfba_pkg.sv =====
package bfba_pkg;

	localparam int HEAP_BYTES   = 131072;
	localparam int MAX_BLOCKS   = 256;
	localparam int HEADER_BYTES = 16;

	localparam int ADDR_W = 17;
	localparam int SIZE_W = 18;
	localparam int NEED_W = SIZE_W + 1;
	localparam int BRK_W  = $clog2(HEAP_BYTES + 1);
	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int SUM_W  = NEED_W + 1;

	localparam logic [NEED_W-1:0] ROUND_ADD  = NEED_W'(3);
	localparam logic [NEED_W-1:0] ROUND_MASK = ~NEED_W'(3);

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		STS_ALLOC     = 3'd0,
		STS_ZERO      = 3'd1,
		STS_NOSPACE   = 3'd2,
		STS_MARKED    = 3'd3,
		STS_RECLAIMED = 3'd4,
		STS_UNKNOWN   = 3'd5
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              is_free;
	} entry_t;

endpackage

// ===== sv/best_fit_block_allocator_top.sv =====
// Best-fit block allocator. Pulse start with command, request_size and
// payload_address while busy is low; the transaction is taken at that edge.
// A zero-size allocate answers in the next cycle without going busy. Any other
// transaction reads the block table out of a single-port-read memory one entry
// per cycle through the scan state, then the finish state sets the result_valid
// strobe; busy drops in the cycle the strobe is shown. The result is on
// result_address and status for exactly one cycle and cannot be stalled. The
// table is written back in the last cycle of a transaction, before the next one
// can read it. The table needs no clearing after reset.
module best_fit_block_allocator_top import bfba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  logic [SIZE_W-1:0] request_size,
	input  logic [ADDR_W-1:0] payload_address,
	output logic              result_valid,
	output logic [ADDR_W-1:0] result_address,
	output logic [2:0]        status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [NEED_W-1:0] need_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  count_q;
	logic [BRK_W-1:0]  brk_q;
	logic [CNT_W-1:0]  issue_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	entry_t            rd_data_s1;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	entry_t            hit_ent_q;

	entry_t            mem [MAX_BLOCKS];

	logic              accept;
	logic [NEED_W-1:0] need_in;
	logic              fits;
	logic              better;
	logic              matches_addr;
	logic              no_room;
	logic              is_last;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign need_in = ({1'b0, request_size} + ROUND_ADD) & ROUND_MASK;

	assign fits = rd_data_s1.is_free && ({1'b0, rd_data_s1.size} >= need_q);
	assign better = !hit_q || (hit_ent_q.size > rd_data_s1.size);
	assign matches_addr = (({1'b0, rd_data_s1.start} + (ADDR_W + 1)'(HEADER_BYTES))
		== {1'b0, addr_q});
	assign no_room = (count_q == CNT_W'(MAX_BLOCKS))
		|| (({(SUM_W - BRK_W)'(0), brk_q} + SUM_W'(HEADER_BYTES) + {1'b0, need_q})
		> SUM_W'(HEAP_BYTES));
	assign is_last = ({1'b0, hit_idx_q} + CNT_W'(1)) == count_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_data = hit_ent_q;
		if (state_q == S_FINISH) begin
			if (cmd_q == CMD_ALLOC) begin
				if (hit_q) begin
					wr_en           = 1'b1;
					wr_data.is_free = 1'b0;
				end else if (!no_room) begin
					wr_en           = 1'b1;
					wr_addr         = count_q[IDX_W-1:0];
					wr_data.start   = brk_q[ADDR_W-1:0];
					wr_data.size    = need_q[SIZE_W-1:0];
					wr_data.is_free = 1'b0;
				end
			end else if (hit_q && !is_last) begin
				wr_en           = 1'b1;
				wr_data.is_free = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[issue_q[IDX_W-1:0]];
		idx_s1     <= issue_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			brk_q          <= '0;
			issue_q        <= '0;
			vld_s1         <= 1'b0;
			hit_q          <= 1'b0;
			result_valid   <= 1'b0;
			result_address <= '0;
			status         <= STS_ALLOC;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q   <= cmd_t'(command);
						need_q  <= need_in;
						addr_q  <= payload_address;
						issue_q <= '0;
						vld_s1  <= 1'b0;
						hit_q   <= 1'b0;
						if (command == CMD_ALLOC && request_size == '0) begin
							result_valid   <= 1'b1;
							result_address <= '0;
							status         <= STS_ZERO;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					vld_s1 <= (issue_q != count_q);
					if (issue_q != count_q) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (vld_s1) begin
						if (cmd_q == CMD_ALLOC) begin
							if (fits && better) begin
								hit_q     <= 1'b1;
								hit_idx_q <= idx_s1;
								hit_ent_q <= rd_data_s1;
							end
						end else if (!hit_q && matches_addr) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
							hit_ent_q <= rd_data_s1;
						end
					end
					if (issue_q == count_q && !vld_s1) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q        <= S_IDLE;
					result_valid   <= 1'b1;
					result_address <= '0;
					if (cmd_q == CMD_ALLOC) begin
						if (hit_q) begin
							result_address <= hit_ent_q.start + ADDR_W'(HEADER_BYTES);
							status         <= STS_ALLOC;
						end else if (no_room) begin
							status <= STS_NOSPACE;
						end else begin
							result_address <= brk_q[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
							status         <= STS_ALLOC;
							count_q        <= count_q + CNT_W'(1);
							brk_q          <= BRK_W'(({(SUM_W - BRK_W)'(0), brk_q}
								+ SUM_W'(HEADER_BYTES) + {1'b0, need_q}));
						end
					end else if (!hit_q) begin
						status <= STS_UNKNOWN;
					end else if (is_last) begin
						status  <= STS_RECLAIMED;
						brk_q   <= {(BRK_W - ADDR_W)'(0), hit_ent_q.start};
						count_q <= count_q - CNT_W'(1);
					end else begin
						status <= STS_MARKED;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/bfba_checker.sv =====
`include "best_fit_block_allocator_top_macros.svh"

module bfba_checker import bfba_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              command,
	input logic [SIZE_W-1:0] request_size,
	input logic [ADDR_W-1:0] payload_address,
	input logic              result_valid,
	input logic [ADDR_W-1:0] result_address,
	input logic [2:0]        status
);

	logic zero_req;
	logic long_req;

	assign zero_req = start && !busy && command == CMD_ALLOC && request_size == '0;
	assign long_req = start && !busy && !zero_req;

	`BFBA_ASSERT_NXT(a_zero_answer, clk, arst_n, zero_req, result_valid && status == STS_ZERO, "zero-size transaction not answered next cycle")
	`BFBA_ASSERT_NXT(a_long_busy, clk, arst_n, long_req, busy && !result_valid, "table transaction did not go busy")
	`BFBA_ASSERT_NOW(a_done_idle, clk, arst_n, $fell(busy), result_valid, "busy dropped without a result")
	`BFBA_ASSERT_NOW(a_addr_zero, clk, arst_n, result_valid && status != STS_ALLOC, result_address == '0, "nonzero address on a failed transaction")
	`BFBA_ASSERT_NOW(a_addr_hdr, clk, arst_n, result_valid && status == STS_ALLOC, result_address >= ADDR_W'(HEADER_BYTES), "allocated address inside a header")

endmodule

bind best_fit_block_allocator_top bfba_checker u_bfba_checker (.*);

// ===== verif/best_fit_block_allocator_checker.sv =====
module best_fit_block_allocator_checker import bfba_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              command,
	input  logic [SIZE_W-1:0] request_size,
	input  logic [ADDR_W-1:0] payload_address,
	input  logic              result_valid,
	input  logic [ADDR_W-1:0] result_address,
	input  logic [2:0]        status,
	output int                fail_count,
	output int                outstanding,
	output int                txn_count,
	output int                placed_count,
	output int                refused_count,
	output int                peak_fill
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [ADDR_W-1:0] address;
		status_t           code;
	} outcome_t;

	entry_t           block_tab [MAX_BLOCKS];
	logic [CNT_W-1:0] tab_count;
	logic [BRK_W-1:0] heap_top;
	outcome_t         awaited_outcomes [$];
	int               mismatches;
	int               txns;
	int               placed;
	int               refused;
	int               peak;

	task automatic predict_outcome(input logic cmd, input logic [SIZE_W-1:0] req,
			input logic [ADDR_W-1:0] pay, output outcome_t res);
		logic [NEED_W-1:0] need;
		int                best;
		int                hit;
		int                i;
		res.address = '0;
		if (cmd == CMD_ALLOC) begin
			if (req == '0) begin
				res.code = STS_ZERO;
			end else begin
				need = ({1'b0, req} + 3) & ~NEED_W'(3);
				best = -1;
				for (i = 0; i < int'(tab_count); i++) begin
					if (block_tab[i].is_free && {1'b0, block_tab[i].size} >= need &&
							(best < 0 || block_tab[i].size < block_tab[best].size)) begin
						best = i;
					end
				end
				if (best >= 0) begin
					block_tab[best].is_free = 1'b0;
					res.address = block_tab[best].start + HEADER_BYTES;
					res.code = STS_ALLOC;
				end else if (int'(tab_count) >= MAX_BLOCKS ||
						int'(heap_top) + HEADER_BYTES + int'(need) > HEAP_BYTES) begin
					res.code = STS_NOSPACE;
				end else begin
					block_tab[tab_count].start = heap_top[ADDR_W-1:0];
					block_tab[tab_count].size = need[SIZE_W-1:0];
					block_tab[tab_count].is_free = 1'b0;
					res.address = heap_top + HEADER_BYTES;
					res.code = STS_ALLOC;
					heap_top = heap_top + HEADER_BYTES + need;
					tab_count = tab_count + 1'b1;
				end
			end
		end else begin
			hit = -1;
			for (i = 0; i < int'(tab_count); i++) begin
				if (hit < 0 && int'(block_tab[i].start) + HEADER_BYTES == int'(pay)) begin
					hit = i;
				end
			end
			if (hit < 0) begin
				res.code = STS_UNKNOWN;
			end else if (hit == int'(tab_count) - 1) begin
				heap_top = block_tab[hit].start;
				tab_count = tab_count - 1'b1;
				res.code = STS_RECLAIMED;
			end else begin
				block_tab[hit].is_free = 1'b1;
				res.code = STS_MARKED;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			tab_count = '0;
			heap_top = '0;
			awaited_outcomes.delete();
			mismatches = 0;
			txns = 0;
			placed = 0;
			refused = 0;
			peak = 0;
			fail_count <= 0;
			outstanding <= 0;
			txn_count <= 0;
			placed_count <= 0;
			refused_count <= 0;
			peak_fill <= 0;
		end else begin
			if (result_valid === 1'b1) begin
				if (awaited_outcomes.size() == 0) begin
					$error("unexpected result: result_address %0d, status %0d",
						result_address, status);
					mismatches++;
				end else begin
					want = awaited_outcomes.pop_front();
					if (result_address !== want.address) begin
						$error("result_address: expected %0d, got %0d",
							want.address, result_address);
						mismatches++;
					end
					if (status !== want.code) begin
						$error("status: expected %0d, got %0d", want.code, status);
						mismatches++;
					end
					if (want.code == STS_ALLOC) placed++;
					if (want.code == STS_NOSPACE) refused++;
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				predict_outcome(command, request_size, payload_address, want);
				awaited_outcomes.push_back(want);
				txns++;
				if (int'(tab_count) > peak) peak = int'(tab_count);
			end
			fail_count <= mismatches;
			outstanding <= awaited_outcomes.size();
			txn_count <= txns;
			placed_count <= placed;
			refused_count <= refused;
			peak_fill <= peak;
		end
	end

endmodule

// ===== verif/best_fit_block_allocator_top_tb.sv =====
module best_fit_block_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bfba_pkg::*;

	typedef enum logic [1:0] {
		MIX_GROW_SMALL,
		MIX_GROW_LARGE,
		MIX_CHURN,
		MIX_SHRINK
	} mix_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              command;
	logic [SIZE_W-1:0] request_size;
	logic [ADDR_W-1:0] payload_address;
	logic              result_valid;
	logic [ADDR_W-1:0] result_address;
	logic [2:0]        status;

	int                fail_count;
	int                outstanding;
	int                txn_count;
	int                placed_count;
	int                refused_count;
	int                peak_fill;

	logic              steady;
	logic [ADDR_W-1:0] live_payloads [$];
	logic [ADDR_W-1:0] released_payloads [$];

	best_fit_block_allocator_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.request_size    (request_size),
		.payload_address (payload_address),
		.result_valid    (result_valid),
		.result_address  (result_address),
		.status          (status)
	);

	best_fit_block_allocator_checker u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.request_size    (request_size),
		.payload_address (payload_address),
		.result_valid    (result_valid),
		.result_address  (result_address),
		.status          (status),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.txn_count       (txn_count),
		.placed_count    (placed_count),
		.refused_count   (refused_count),
		.peak_fill       (peak_fill)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid === 1'b1 && status == STS_ALLOC) begin
			live_payloads.push_back(result_address);
		end
	end

	task automatic send_txn(input logic cmd, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] pa);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 40) gap = 0;
		else if (r < 85) gap = $urandom_range(1, 3);
		else if (r < 97) gap = $urandom_range(4, 15);
		else gap = $urandom_range(16, 60);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			command <= $urandom;
			request_size <= $urandom;
			payload_address <= $urandom;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		command <= cmd;
		request_size <= sz;
		payload_address <= pa;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int                r;
		int                n;
		int                pick;
		int                free_cut;
		mix_t              mix;
		logic [SIZE_W-1:0] sz;
		logic [ADDR_W-1:0] pa;
		steady = 1'b0;
		start = 1'b0;
		command = CMD_ALLOC;
		request_size = '0;
		payload_address = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_txn(CMD_ALLOC, 0, 0);
		send_txn(CMD_FREE, 0, 0);
		send_txn(CMD_ALLOC, 1, 0);
		send_txn(CMD_ALLOC, 131072, 0);
		send_txn(CMD_ALLOC, 5, 0);
		send_txn(CMD_ALLOC, 8, 0);
		send_txn(CMD_ALLOC, 3, 0);
		send_txn(CMD_FREE, 0, 36);
		send_txn(CMD_FREE, 0, 60);
		send_txn(CMD_ALLOC, 6, 0);
		send_txn(CMD_FREE, 0, 16);
		send_txn(CMD_ALLOC, 2, 0);
		send_txn(CMD_ALLOC, 7, 0);
		send_txn(CMD_FREE, 0, 60);
		send_txn(CMD_FREE, 0, 60);
		send_txn(CMD_FREE, 0, 84);
		send_txn(CMD_FREE, 0, 60);
		send_txn(CMD_FREE, 0, 131071);
		send_txn(CMD_ALLOC, 130000, 0);
		send_txn(CMD_ALLOC, 1000, 0);
		send_txn(CMD_ALLOC, 996, 0);
		send_txn(CMD_ALLOC, 1, 0);
		send_txn(CMD_FREE, 0, 130076);
		send_txn(CMD_FREE, 0, 60);
		send_txn(CMD_FREE, 0, 36);
		send_txn(CMD_FREE, 0, 16);

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin mix = MIX_GROW_SMALL; n = 340; end
				1: begin mix = MIX_CHURN; n = 150; end
				2: begin mix = MIX_SHRINK; n = 200; end
				3: begin mix = MIX_GROW_LARGE; n = 120; end
				4: begin mix = MIX_CHURN; n = 110; end
				default: begin mix = MIX_SHRINK; n = 130; end
			endcase
			steady = ($urandom_range(0, 3) == 0);
			free_cut = (mix == MIX_SHRINK) ? 80 : (mix == MIX_CHURN) ? 50 : 10;
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r >= free_cut) begin
					r = $urandom_range(0, 99);
					case (mix)
						MIX_GROW_SMALL: sz = (r < 3) ? 0 : $urandom_range(1, 64);
						MIX_GROW_LARGE: sz = (r < 3) ? 0 : (r < 8) ?
							$urandom_range(100000, 131072) : $urandom_range(256, 8192);
						default: sz = (r < 3) ? 0 : (r < 60) ? $urandom_range(1, 128) :
							(r < 85) ? $urandom_range(129, 2048) :
							(r < 95) ? $urandom_range(2049, 32768) :
							$urandom_range(32769, 131072);
					endcase
					send_txn(CMD_ALLOC, sz, $urandom);
				end else begin
					r = $urandom_range(0, 99);
					if (r < 60 && live_payloads.size() > 0) begin
						pick = (mix == MIX_SHRINK && $urandom_range(0, 9) < 7) ?
							live_payloads.size() - 1 : $urandom_range(0, live_payloads.size() - 1);
						pa = live_payloads[pick];
						live_payloads.delete(pick);
						released_payloads.push_back(pa);
					end else if (r < 80 && released_payloads.size() > 0) begin
						pa = released_payloads[$urandom_range(0, released_payloads.size() - 1)];
					end else if (r < 90) begin
						pa = $urandom_range(0, 32767) << 2;
					end else begin
						pa = $urandom;
					end
					send_txn(CMD_FREE, $urandom, pa);
				end
			end
		end

		@(negedge clk);
		start <= 1'b0;
		n = 0;
		while (outstanding != 0 && n < 2000) begin
			@(posedge clk);
			n++;
		end
		repeat (300) @(posedge clk);
		if (outstanding != 0) $error("%0d results never arrived", outstanding);
		$display("Ran %0d allocate/free transactions: %0d placed a block, %0d refused for space.",
			txn_count, placed_count, refused_count);
		$display("Block table reached %0d of %0d entries.", peak_fill, MAX_BLOCKS);
		if (fail_count == 0 && outstanding == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
